// ----- rtl/core/rit_pkg.sv -----
// Shared types and codes for the request ID tracker with timeout.
// Holds the request and response beat structs and the action and event codes.
// No dependencies.
package rit_pkg;

   // Request beat
   typedef struct packed {
      logic [1:0]  action;
      logic [5:0]  reply_id;
      logic [31:0] now_seconds;
   } req_type;

   // Response beat
   typedef struct packed {
      logic [2:0] event_res;
      logic [5:0] slot_id;
      logic [6:0] open_entries;
      logic       last_of_run;
   } rsp_type;

   // Action codes
   localparam logic [1:0] ACT_ALLOC = 2'd0;
   localparam logic [1:0] ACT_REPLY = 2'd1;
   localparam logic [1:0] ACT_SCAN  = 2'd2;

   // Event codes
   localparam logic [2:0] EV_ALLOCATED   = 3'd0;
   localparam logic [2:0] EV_ALLOC_BUSY  = 3'd1;
   localparam logic [2:0] EV_REPLY_MATCH = 3'd2;
   localparam logic [2:0] EV_REPLY_UNK   = 3'd3;
   localparam logic [2:0] EV_TIMED_OUT   = 3'd4;
   localparam logic [2:0] EV_NONE_EXP    = 3'd5;

   // Timeout register reset value
   localparam logic [7:0] TIMEOUT_RESET = 8'd5;

endpackage

// ----- rtl/core/rit_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the send-time table of the request ID tracker. No dependencies.
module rit_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, register one read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/request_id_tracker_with_timeout.sv -----
// Outstanding request table with timeout: top level.
// Depends on rit_pkg and rit_ram.
//
// Usage: a request beat is taken when start is high and busy is low. A reply
// never raises busy; its response appears on the next cycle. An allocate walks
// the active bits one entry per cycle starting after the last slot handed out,
// so it keeps busy high until it claims an entry, and its response comes with
// the cycle busy drops. A timeout scan reads the send-time RAM one entry per
// cycle through its one read port; expired entries are reported as they are
// found, at most one response per cycle, each held back one find so the final
// one can carry last_of_run. Every rsp_strobe cycle is a response beat and must
// be taken; there is no back pressure. The user must write the timeout with
// csr_we only while the block is idle; the block itself does not enforce it.
module request_id_tracker_with_timeout
   import rit_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_strobe,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   state_type          state_ff, state_in;
   logic               busy_ff, busy_in;
   logic [ENTRIES-1:0] active_ff, active_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic [IDX_W-1:0]   step_ff, step_in;
   logic [IDX_W-1:0]   issue_idx_ff, issue_idx_in;
   logic               issuing_ff, issuing_in;
   logic               stage_vld_ff, stage_vld_in;
   logic [IDX_W-1:0]   stage_idx_ff, stage_idx_in;
   logic               stage_last_ff, stage_last_in;
   logic               pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]   pend_slot_ff, pend_slot_in;
   logic [CNT_W-1:0]   pend_open_ff, pend_open_in;
   logic               rsp_vld_ff, rsp_vld_in;
   rsp_type            rsp_ff, rsp_in;
   req_type            req_ff, req_in;
   logic [7:0]         timeout_ff, timeout_in;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [31:0]        ram_rdata;
   logic [IDX_W-1:0]   nxt_ptr;
   logic [31:0]        age;
   logic               expire;
   logic               rid_ok;
   logic [CNT_W-1:0]   count_dec;

   // Send-time table
   rit_ram #(
      .WIDTH (32),
      .DEPTH (ENTRIES)
   ) u_time_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_ff.now_seconds),
      .rd_addr (issue_idx_ff),
      .rd_data (ram_rdata)
   );

   // Shared helpers
   assign nxt_ptr   = (ptr_ff == IDX_W'(ENTRIES - 1)) ? '0 : ptr_ff + IDX_W'(1);
   assign age       = req_ff.now_seconds - ram_rdata;
   assign expire    = stage_vld_ff && active_ff[stage_idx_ff] &&
                      (age >= {24'd0, timeout_ff});
   assign rid_ok    = ({1'b0, req_data.reply_id} < 7'(ENTRIES));
   assign count_dec = (count_ff != '0) ? count_ff - CNT_W'(1) : count_ff;
   assign ram_waddr = nxt_ptr;

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      busy_in       = busy_ff;
      active_in     = active_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      step_in       = step_ff;
      issue_idx_in  = issue_idx_ff;
      issuing_in    = issuing_ff;
      stage_vld_in  = 1'b0;
      stage_idx_in  = stage_idx_ff;
      stage_last_in = 1'b0;
      pend_vld_in   = pend_vld_ff;
      pend_slot_in  = pend_slot_ff;
      pend_open_in  = pend_open_ff;
      rsp_vld_in    = 1'b0;
      rsp_in        = rsp_ff;
      req_in        = req_ff;
      timeout_in    = csr_we ? csr_wdata : timeout_ff;
      ram_we        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               case (req_data.action)
                  ACT_ALLOC: begin
                     state_in = ST_ALLOC;
                     busy_in  = 1'b1;
                     step_in  = '0;
                  end
                  ACT_REPLY: begin
                     // Match or reject the reply
                     rsp_vld_in         = 1'b1;
                     rsp_in.slot_id     = req_data.reply_id;
                     rsp_in.last_of_run = 1'b1;
                     if (rid_ok && active_ff[req_data.reply_id[IDX_W-1:0]]) begin
                        active_in[req_data.reply_id[IDX_W-1:0]] = 1'b0;
                        count_in            = count_dec;
                        rsp_in.event_res    = EV_REPLY_MATCH;
                        rsp_in.open_entries = 7'(count_dec);
                     end else begin
                        rsp_in.event_res    = EV_REPLY_UNK;
                        rsp_in.open_entries = 7'(count_ff);
                     end
                  end
                  ACT_SCAN: begin
                     state_in     = ST_SCAN;
                     busy_in      = 1'b1;
                     issue_idx_in = '0;
                     issuing_in   = 1'b1;
                     pend_vld_in  = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_ALLOC: begin
            // Advance one entry; claim a free one or take over after a full lap
            ptr_in  = nxt_ptr;
            step_in = step_ff + IDX_W'(1);
            if (!active_ff[nxt_ptr] || (step_ff == IDX_W'(ENTRIES - 1))) begin
               ram_we             = 1'b1;
               active_in[nxt_ptr] = 1'b1;
               state_in           = ST_IDLE;
               busy_in            = 1'b0;
               rsp_vld_in         = 1'b1;
               rsp_in.slot_id     = 6'(nxt_ptr);
               rsp_in.last_of_run = 1'b1;
               if (!active_ff[nxt_ptr]) begin
                  rsp_in.event_res = EV_ALLOCATED;
                  if (count_ff < CNT_W'(ENTRIES)) begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end else begin
                  rsp_in.event_res = EV_ALLOC_BUSY;
               end
               rsp_in.open_entries = 7'(count_in);
            end
         end

         ST_SCAN: begin
            // Issue one send-time read per cycle
            if (issuing_ff) begin
               stage_vld_in  = 1'b1;
               stage_idx_in  = issue_idx_ff;
               stage_last_in = (issue_idx_ff == IDX_W'(ENTRIES - 1));
               if (issue_idx_ff == IDX_W'(ENTRIES - 1)) begin
                  issuing_in = 1'b0;
               end else begin
                  issue_idx_in = issue_idx_ff + IDX_W'(1);
               end
            end
            // Compare age; drop expired entry, send any held beat and hold this one as pending beat
            if (expire) begin
               active_in[stage_idx_ff] = 1'b0;
               count_in                = count_dec;
               if (pend_vld_ff) begin
                  rsp_vld_in          = 1'b1;
                  rsp_in.event_res    = EV_TIMED_OUT;
                  rsp_in.slot_id      = 6'(pend_slot_ff);
                  rsp_in.open_entries = 7'(pend_open_ff);
                  rsp_in.last_of_run  = 1'b0;
               end
               pend_vld_in  = 1'b1;
               pend_slot_in = stage_idx_ff;
               pend_open_in = count_dec;
            end
            if (stage_vld_ff && stage_last_ff) begin
               state_in = ST_FLUSH;
            end
         end

         ST_FLUSH: begin
            // Close the run with the held beat or a nothing-expired beat
            rsp_vld_in         = 1'b1;
            rsp_in.last_of_run = 1'b1;
            if (pend_vld_ff) begin
               rsp_in.event_res    = EV_TIMED_OUT;
               rsp_in.slot_id      = 6'(pend_slot_ff);
               rsp_in.open_entries = 7'(pend_open_ff);
            end else begin
               rsp_in.event_res    = EV_NONE_EXP;
               rsp_in.slot_id      = 6'd0;
               rsp_in.open_entries = 7'(count_ff);
            end
            pend_vld_in = 1'b0;
            state_in    = ST_IDLE;
            busy_in     = 1'b0;
         end

         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         busy_ff       <= 1'b0;
         active_ff     <= '0;
         count_ff      <= '0;
         ptr_ff        <= '0;
         step_ff       <= '0;
         issue_idx_ff  <= '0;
         issuing_ff    <= 1'b0;
         stage_vld_ff  <= 1'b0;
         stage_last_ff <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         timeout_ff    <= TIMEOUT_RESET;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= busy_in;
         active_ff     <= active_in;
         count_ff      <= count_in;
         ptr_ff        <= ptr_in;
         step_ff       <= step_in;
         issue_idx_ff  <= issue_idx_in;
         issuing_ff    <= issuing_in;
         stage_vld_ff  <= stage_vld_in;
         stage_last_ff <= stage_last_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
         timeout_ff    <= timeout_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      stage_idx_ff <= stage_idx_in;
      pend_slot_ff <= pend_slot_in;
      pend_open_ff <= pend_open_in;
      rsp_ff       <= rsp_in;
      req_ff       <= req_in;
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_vld_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- rtl/core/rit_checker.sv -----
// Port-level assertions for the request ID tracker with timeout.
// Depends on rit_pkg; bound to request_id_tracker_with_timeout below.
module rit_checker
   import rit_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // Count never passes the table size
   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.open_entries <= 7'(ENTRIES)))
      else $error("open_entries beyond table size");

   // Only timed-out beats may leave a run open
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.event_res != EV_TIMED_OUT)) |-> rsp_data.last_of_run)
      else $error("single-beat event without last_of_run");

   // Nothing-expired beat reports slot zero
   a_none_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.event_res == EV_NONE_EXP)) |-> (rsp_data.slot_id == 6'd0))
      else $error("nothing-expired beat with nonzero slot");

   // Reply answered next cycle with its own id
   a_reply_next: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.action == ACT_REPLY)) |=>
         (rsp_strobe && (rsp_data.slot_id == $past(req_data.reply_id)) &&
          ((rsp_data.event_res == EV_REPLY_MATCH) || (rsp_data.event_res == EV_REPLY_UNK))))
      else $error("reply not answered on the next cycle");

   // Allocate and scan hold the block busy
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && ((req_data.action == ACT_ALLOC) || (req_data.action == ACT_SCAN)))
         |=> busy)
      else $error("busy not raised for a multi-cycle action");

endmodule

bind request_id_tracker_with_timeout rit_checker #(
   .ENTRIES (ENTRIES)
) u_rit_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

// ----- tb/rit_event_checker.sv -----
// Scoreboard for the request ID tracker: watches request, response and CSR ports.
// Keeps its own copy of the slot table and compares every response beat in order.
// Depends on rit_pkg.
`timescale 1ns / 100ps

module rit_event_checker
   import rit_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  req_type    req_data,
   input  logic       rsp_strobe,
   input  rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   output int         mismatches,
   output int         pending
);

   // Shadow of the slot table
   logic [ENTRIES-1:0] slot_live;
   logic [31:0]        slot_sent_s [ENTRIES];
   int                 cursor;
   logic [6:0]         open_n;
   logic [7:0]         timeout_s;

   // Response beats predicted but not yet seen
   rsp_type            expected_events [$];

   // Bring the shadow table to its after-reset state
   function automatic void clear_table();
      slot_live = '0;
      foreach (slot_sent_s[i]) slot_sent_s[i] = '0;
      cursor    = 0;
      open_n    = '0;
      timeout_s = TIMEOUT_RESET;
      expected_events.delete();
   endfunction

   function automatic rsp_type make_event(logic [2:0] ev, int slot, logic last);
      rsp_type e;
      e.event_res    = ev;
      e.slot_id      = 6'(slot);
      e.open_entries = open_n;
      e.last_of_run  = last;
      return e;
   endfunction

   function automatic void free_slot(int slot);
      slot_live[slot] = 1'b0;
      if (open_n > 0) open_n = open_n - 7'd1;
   endfunction

   // Apply one accepted request to the shadow table and queue its responses
   function automatic void predict_table_events(req_type req);
      bit          found;
      bit          have_held;
      rsp_type     held;
      logic [31:0] age;
      found     = 1'b0;
      have_held = 1'b0;
      held      = '0;
      case (req.action)
         ACT_ALLOC: begin
            // Walk round-robin from after the last slot handed out
            for (int i = 0; i < ENTRIES; i++) begin
               cursor = (cursor + 1) % ENTRIES;
               if (!slot_live[cursor]) begin
                  found = 1'b1;
                  break;
               end
            end
            slot_sent_s[cursor] = req.now_seconds;
            slot_live[cursor]   = 1'b1;
            if (found && open_n < ENTRIES) open_n = open_n + 7'd1;
            expected_events.push_back(
               make_event(found ? EV_ALLOCATED : EV_ALLOC_BUSY, cursor, 1'b1));
         end
         ACT_REPLY: begin
            if (int'(req.reply_id) < ENTRIES && slot_live[req.reply_id]) begin
               free_slot(int'(req.reply_id));
               expected_events.push_back(
                  make_event(EV_REPLY_MATCH, int'(req.reply_id), 1'b1));
            end else begin
               expected_events.push_back(
                  make_event(EV_REPLY_UNK, int'(req.reply_id), 1'b1));
            end
         end
         ACT_SCAN: begin
            // Hold each expiry back by one find so the final one carries last_of_run
            for (int i = 0; i < ENTRIES; i++) begin
               age = req.now_seconds - slot_sent_s[i];
               if (slot_live[i] && age >= 32'(timeout_s)) begin
                  free_slot(i);
                  if (have_held) expected_events.push_back(held);
                  held      = make_event(EV_TIMED_OUT, i, 1'b0);
                  have_held = 1'b1;
               end
            end
            if (have_held) begin
               held.last_of_run = 1'b1;
               expected_events.push_back(held);
            end else begin
               expected_events.push_back(make_event(EV_NONE_EXP, 0, 1'b1));
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void note_field(string name, logic [31:0] want, logic [31:0] got);
      $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
   endfunction

   // Compare one response beat against the oldest prediction
   function automatic void check_event(rsp_type got);
      rsp_type want;
      if (expected_events.size() == 0) begin
         $display("%0t: unexpected response: expected none, actual event %0d slot %0d",
                  $time, got.event_res, got.slot_id,
                  " open %0d last %0b", got.open_entries, got.last_of_run);
         mismatches++;
         return;
      end
      want = expected_events.pop_front();
      if (got.event_res !== want.event_res)
         note_field("event_res", 32'(want.event_res), 32'(got.event_res));
      if (got.slot_id !== want.slot_id)
         note_field("slot_id", 32'(want.slot_id), 32'(got.slot_id));
      if (got.open_entries !== want.open_entries)
         note_field("open_entries", 32'(want.open_entries), 32'(got.open_entries));
      if (got.last_of_run !== want.last_of_run)
         note_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
   endfunction

   // Sample every port at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         clear_table();
      end else begin
         if (csr_we) timeout_s = csr_wdata;
         if (start && !busy) predict_table_events(req_data);
         if (rsp_strobe) check_event(rsp_data);
      end
      pending = expected_events.size();
   end

endmodule

// ----- tb/request_id_tracker_with_timeout_tb.sv -----
// Testbench top for the request ID tracker: clock, reset, request stimulus and verdict.
// Depends on rit_pkg, request_id_tracker_with_timeout and rit_event_checker.
`timescale 1ns / 100ps

module request_id_tracker_with_timeout_tb;
   import rit_pkg::*;

   localparam int         ENTRIES        = 64;
   localparam int         WATCHDOG_LIMIT = 1000;
   localparam int         MAX_GAP        = 40;
   localparam logic [1:0] ACT_UNUSED     = 2'd3;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   logic       csr_we;
   logic [7:0] csr_wdata;

   int          mismatches;
   int          pending;
   int          quiet_cycles;
   logic [31:0] sec_now;

   request_id_tracker_with_timeout #(
      .ENTRIES (ENTRIES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   rit_event_checker #(
      .ENTRIES (ENTRIES)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // End the run if neither a request nor a response beat moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic req_type make_req(logic [1:0] act, logic [5:0] id, logic [31:0] secs);
      req_type r;
      r.action      = act;
      r.reply_id    = id;
      r.now_seconds = secs;
      return r;
   endfunction

   // Idle for a random gap, then hold the beat until the block takes it
   task automatic send_request(input req_type r, input int idle_pct);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         gap++;
      end
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and wait until every predicted response has come back
   task automatic wait_results_in();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   // Drain, then give the block time to finish work that makes no response
   task automatic wait_drained();
      wait_results_in();
      repeat (ENTRIES + 8) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [7:0] value);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // Edge cases: empty scan, wrapped ages, repeat and stale replies, unused action
   task automatic run_directed();
      send_request(make_req(ACT_SCAN,   6'd0,  32'd0),          0);
      send_request(make_req(ACT_ALLOC,  6'd0,  32'd0),          0);
      send_request(make_req(ACT_ALLOC,  6'd0,  32'hFFFF_FFFE),  0);
      send_request(make_req(ACT_REPLY,  6'd1,  32'd7),          0);
      send_request(make_req(ACT_REPLY,  6'd1,  32'd7),          0);
      send_request(make_req(ACT_REPLY,  6'd63, 32'd7),          0);
      send_request(make_req(ACT_UNUSED, 6'd63, 32'hFFFF_FFFF),  0);
      send_request(make_req(ACT_SCAN,   6'd0,  32'd3),          0);
      send_request(make_req(ACT_ALLOC,  6'd0,  32'd100),        0);
      send_request(make_req(ACT_ALLOC,  6'd0,  32'd100),        0);
      send_request(make_req(ACT_SCAN,   6'd0,  32'd104),        0);
      send_request(make_req(ACT_SCAN,   6'd0,  32'd105),        0);
      send_request(make_req(ACT_REPLY,  6'd0,  32'd105),        0);
      send_request(make_req(ACT_ALLOC,  6'd42, 32'hFFFF_FFFF),  0);
      // Zero timeout expires an entry of age zero
      wait_drained();
      write_timeout(8'd0);
      send_request(make_req(ACT_SCAN,   6'd0,  32'hFFFF_FFFF),  0);
   endtask

   // Random mix of allocates, replies and scans; unused-action noise is not counted
   task automatic run_phase(input int n_items, input int idle_pct, input int alloc_w,
                            input int reply_w, input int max_step);
      int done;
      int pick;
      done = 0;
      while (done < n_items) begin
         pick = $urandom_range(99, 0);
         // Advance the time of day, with a rare jump in the looser phases
         if (max_step > 1 && $urandom_range(99, 0) == 0) begin
            sec_now = sec_now + $urandom();
         end else begin
            sec_now = sec_now + $urandom_range(max_step, 0);
         end
         if (pick < 3) begin
            send_request(make_req(ACT_UNUSED, 6'($urandom), $urandom()), idle_pct);
         end else begin
            if (pick < 3 + alloc_w) begin
               send_request(make_req(ACT_ALLOC, 6'($urandom), sec_now), idle_pct);
            end else if (pick < 3 + alloc_w + reply_w) begin
               send_request(make_req(ACT_REPLY, 6'($urandom_range(63, 0)), sec_now),
                            idle_pct);
            end else begin
               send_request(make_req(ACT_SCAN, 6'($urandom), sec_now), idle_pct);
            end
            done++;
         end
         // Now and then hold off until the table has answered everything
         if ($urandom_range(49, 0) == 0) wait_results_in();
      end
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_wdata = '0;
      sec_now   = 32'd1000;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // Long timeout and mostly allocates: fill the table and overflow it
      wait_drained();
      write_timeout(8'd255);
      run_phase(100, 0, 88, 5, 1);

      // Shortest nonzero timeout with a mostly idle sender
      wait_drained();
      write_timeout(8'd1);
      run_phase(60, 78, 45, 30, 2);

      wait_drained();
      write_timeout(8'd3);
      run_phase(50, 7, 50, 25, 3);

      // Random timeout with the time of day wrapping past zero
      wait_drained();
      write_timeout(8'($urandom_range(254, 2)));
      sec_now = 32'hFFFF_FF80;
      run_phase(60, 0, 60, 22, 4);

      wait_drained();
      write_timeout(TIMEOUT_RESET);
      run_phase(40, 78, 55, 25, 2);

      wait_drained();
      if (pending != 0)
         $display("%0t: %0d expected responses never arrived", $time, pending);
      if (mismatches == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
